// ===== rtl/ble_pkg.sv =====
`default_nettype none

package ble_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 32;

    // Position fields in the chain control cover the full capacity range (up to 127)
    localparam int POS_W = 7;

    localparam int DATA_W = 32;
    localparam int MODE_W = 4;
    localparam int STAT_W = 3;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_LAST_N = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_SECOND = 4'd5;
    localparam logic [MODE_W-1:0] MODE_APP_SIZE   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_INS_BLAST  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_LIST_LE    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_LIST_ALL   = 4'd9;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_LISTED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NONE   = 3'd4;

    // Per-cycle command broadcast to every cell of the chain.
    // shr: cells in (lo, hi] take the left neighbor
    // shl: cells in [lo, hi) take the right neighbor
    // wr:  cell at wpos takes data (wins over a shift)
    typedef struct packed {
        logic              shl;
        logic              shr;
        logic              wr;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic [POS_W-1:0]  wpos;
        logic [DATA_W-1:0] data;
    } ble_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ble_cell.sv =====
`default_nettype none

module ble_cell
    import ble_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              clk,
    input  wire ble_ctl_t          ctl,
    input  wire logic [DATA_W-1:0] left,
    input  wire logic [DATA_W-1:0] right,
    output logic      [DATA_W-1:0] q
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              take_left;
    logic              take_right;
    logic              take_wr;

    // Local decode of the broadcast command
    assign take_wr    = ctl.wr && (MY_POS == ctl.wpos);
    assign take_left  = ctl.shr && (MY_POS > ctl.lo) && (MY_POS <= ctl.hi);
    assign take_right = ctl.shl && (MY_POS >= ctl.lo) && (MY_POS < ctl.hi);

    always_comb
    begin
        value_next = value_reg;
        if (take_wr)
        begin
            value_next = ctl.data;
        end
        else if (take_left)
        begin
            value_next = left;
        end
        else if (take_right)
        begin
            value_next = right;
        end
    end

    // Entry storage, no reset: contents are meaningless until written
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign q = value_reg;

endmodule

`default_nettype wire

// ===== rtl/ble_chain.sv =====
`default_nettype none

module ble_chain
    import ble_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire ble_ctl_t          ctl,
    output logic      [DATA_W-1:0] head
);

    logic [DATA_W-1:0] q [DEPTH];

    // Row of cells, each wired to its two neighbors; the ends see zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = q[i+1];
        end

        ble_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .left  (left_d),
            .right (right_d),
            .q     (q[i])
        );
    end

    assign head = q[0];

endmodule

`default_nettype wire

// ===== rtl/bounded_list_engine.sv =====
`default_nettype none

// Channel  Dir  Signals                  Contents (low bit first)
// s_*      in   tvalid tready tdata tuser tdata: operand[31:0]; tuser: mode[3:0]
// m_*      out  tvalid tready tdata tuser tdata: item_value[31:0], entry_count,
//               tlast                     zero pad to bytes; tuser: status[2:0];
//                                         tlast: last result of the request
//
// Edit requests: the cell chain shifts or writes in a single step.
// A listing rotates the chain one cell per cycle while the output register is free;
// an output stall holds the rotation until the register drains.
// A new request is taken only when no listing is running and the output register
// is free or being drained. Reset clears the count; cell contents need no clear.

module bounded_list_engine
    import ble_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((DATA_W + CNT_W + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // operand[31:0]
    input  wire logic [MODE_W-1:0] s_tuser,   // mode[3:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_W-1:0]  m_tdata,   // item_value[31:0], entry_count, zero pad
    output logic      [STAT_W-1:0] m_tuser,   // status[2:0]
    output logic                   m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIST,
        S_LAST
    } state_t;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [CNT_W-1:0]   rem_reg,     rem_next;
    logic [DATA_W-1:0]  thr_reg,     thr_next;
    logic               all_reg,     all_next;
    logic               pend_reg,    pend_next;
    logic [DATA_W-1:0]  pval_reg,    pval_next;
    logic               mvalid_reg,  mvalid_next;
    logic [DATA_W-1:0]  oval_reg,    oval_next;
    logic [STAT_W-1:0]  ostat_reg,   ostat_next;
    logic               olast_reg,   olast_next;
    logic [CNT_W-1:0]   ocnt_reg,    ocnt_next;

    ble_ctl_t           ctl;
    logic [DATA_W-1:0]  head;
    logic               out_free;
    logic               accept;
    logic               full;
    logic [DATA_W-1:0]  count_ext;
    logic [POS_W-1:0]   cpos;
    logic [POS_W-1:0]   cpos_m1;
    logic               head_match;

    assign out_free  = !mvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_FULL);
    assign count_ext = DATA_W'(count_reg);
    assign cpos      = POS_W'(count_reg);
    assign cpos_m1   = POS_W'(count_reg) - POS_W'(1);
    assign head_match = all_reg || ($signed(head) <= $signed(thr_reg));

    // Request decode, chain command and result selection
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        thr_next    = thr_reg;
        all_next    = all_reg;
        pend_next   = pend_reg;
        pval_next   = pval_reg;
        mvalid_next = mvalid_reg && !m_tready;
        oval_next   = oval_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        ocnt_next   = ocnt_reg;
        ctl         = '0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    // Default: one status result after the edit
                    mvalid_next = 1'b1;
                    oval_next   = '0;
                    olast_next  = 1'b1;
                    ostat_next  = STAT_DONE;
                    unique case (s_tuser) inside
                        MODE_INS_FRONT, MODE_INS_BACK, MODE_APP_SIZE:
                        begin
                            if (full)
                            begin
                                ostat_next = STAT_FULL;
                            end
                            else
                            begin
                                ctl.wr     = 1'b1;
                                ctl.wpos   = (s_tuser == MODE_INS_FRONT) ? '0 : cpos;
                                ctl.data   = (s_tuser == MODE_APP_SIZE) ? count_ext : s_tdata;
                                ctl.shr    = (s_tuser == MODE_INS_FRONT);
                                ctl.lo     = '0;
                                ctl.hi     = cpos;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                ostat_next = STAT_SHORT;
                            end
                            else
                            begin
                                ctl.shl    = (s_tuser == MODE_DEL_FRONT);
                                ctl.lo     = '0;
                                ctl.hi     = cpos_m1;
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        MODE_DEL_LAST_N:
                        begin
                            if (s_tdata[DATA_W-1] || (s_tdata >= count_ext))
                            begin
                                count_next = '0;
                            end
                            else
                            begin
                                count_next = count_reg - s_tdata[CNT_W-1:0];
                            end
                        end
                        MODE_DEL_SECOND:
                        begin
                            if (count_reg < CNT_TWO)
                            begin
                                ostat_next = STAT_SHORT;
                            end
                            else
                            begin
                                ctl.shl    = 1'b1;
                                ctl.lo     = POS_W'(1);
                                ctl.hi     = cpos_m1;
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        MODE_INS_BLAST:
                        begin
                            if (count_reg < CNT_TWO)
                            begin
                                ostat_next = STAT_SHORT;
                            end
                            else if (full)
                            begin
                                ostat_next = STAT_FULL;
                            end
                            else
                            begin
                                ctl.shr    = 1'b1;
                                ctl.lo     = cpos_m1;
                                ctl.hi     = cpos;
                                ctl.wr     = 1'b1;
                                ctl.wpos   = cpos_m1;
                                ctl.data   = s_tdata;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        MODE_LIST_LE, MODE_LIST_ALL:
                        begin
                            thr_next  = s_tdata;
                            all_next  = (s_tuser == MODE_LIST_ALL);
                            pend_next = 1'b0;
                            rem_next  = count_reg;
                            if (count_reg == '0)
                            begin
                                ostat_next = STAT_NONE;
                            end
                            else
                            begin
                                mvalid_next = 1'b0;
                                state_next  = (count_reg == CNT_ONE) ? S_LAST : S_LIST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    ocnt_next = count_next;
                end
            end

            S_LIST, S_LAST:
            begin
                if (out_free && (rem_reg != '0))
                begin
                    // Rotate the occupied part of the chain by one cell
                    ctl.shl  = 1'b1;
                    ctl.lo   = '0;
                    ctl.hi   = cpos_m1;
                    ctl.wr   = 1'b1;
                    ctl.wpos = cpos_m1;
                    ctl.data = head;
                    rem_next = rem_reg - CNT_ONE;
                    if (head_match)
                    begin
                        pend_next = 1'b1;
                        pval_next = head;
                        if (pend_reg)
                        begin
                            mvalid_next = 1'b1;
                            oval_next   = pval_reg;
                            ostat_next  = STAT_LISTED;
                            olast_next  = 1'b0;
                            ocnt_next   = count_reg;
                        end
                    end
                    if (rem_reg == CNT_TWO)
                    begin
                        state_next = S_LAST;
                    end
                end
                else if (out_free && (state_reg == S_LAST))
                begin
                    // Chain back in order: close the listing
                    mvalid_next = 1'b1;
                    oval_next   = pend_reg ? pval_reg : '0;
                    ostat_next  = pend_reg ? STAT_LISTED : STAT_NONE;
                    olast_next  = 1'b1;
                    ocnt_next   = count_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rem_reg    <= '0;
            thr_reg    <= '0;
            all_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            pval_reg   <= '0;
            mvalid_reg <= 1'b0;
            oval_reg   <= '0;
            ostat_reg  <= STAT_DONE;
            olast_reg  <= 1'b0;
            ocnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            thr_reg    <= thr_next;
            all_reg    <= all_next;
            pend_reg   <= pend_next;
            pval_reg   <= pval_next;
            mvalid_reg <= mvalid_next;
            oval_reg   <= oval_next;
            ostat_reg  <= ostat_next;
            olast_reg  <= olast_next;
            ocnt_reg   <= ocnt_next;
        end
    end

    ble_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk  (clk),
        .ctl  (ctl),
        .head (head)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_W'({ocnt_reg, oval_reg});
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("request taken while a listing runs");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(count_reg))
        else $error("count changed during a listing");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_NONE)) |-> m_tlast)
        else $error("nothing-to-list result not marked last");
`endif

endmodule

`default_nettype wire

// ===== test/bounded_list_engine_tb.sv =====
`timescale 1ns / 100ps

module bounded_list_engine_tb;
    import ble_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd10;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    // Random segment flavors
    localparam int SEG_FILL   = 0;
    localparam int SEG_GROW   = 1;
    localparam int SEG_SHRINK = 2;
    localparam int SEG_MIX    = 3;

    localparam int HOLD_AT     = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] operand;
        bit                pause;
    } list_request_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } list_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0] s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [STAT_W-1:0] m_tuser;
    logic              m_tlast;

    // Stimulus and scoreboard state
    list_request_t     queued_requests[$];
    list_result_t      due_results[$];
    list_request_t     next_req;
    logic [DATA_W-1:0] list_vals[DEPTH];
    int                list_len = 0;
    bit                req_taken = 1'b0;
    int                reqs_taken = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    bit                failed = 1'b0;
    int                cycles = 0;
    logic              quiet;

    // No idling on either side while this window of requests goes through
    assign quiet = (reqs_taken >= 150) && (reqs_taken < 200);

    bounded_list_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // operand[31:0]
        .s_tuser  (s_tuser),    // mode[3:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // item_value[31:0], entry_count[5:0], zero pad
        .m_tuser  (m_tuser),    // status[2:0]
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- list predictor ----------------

    task automatic insert_value(input int pos, input logic [DATA_W-1:0] v);
        for (int i = list_len; i > pos; i--)
            list_vals[i] = list_vals[i - 1];
        list_vals[pos] = v;
        list_len++;
    endtask

    task automatic remove_value(input int pos);
        for (int i = pos; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i + 1];
        list_len--;
    endtask

    function automatic bit is_listed(input logic [MODE_W-1:0] mode,
                                     input logic [DATA_W-1:0] v,
                                     input logic [DATA_W-1:0] thr);
        return (mode == MODE_LIST_ALL) || ($signed(v) <= $signed(thr));
    endfunction

    task automatic push_result(input logic [DATA_W-1:0] v, input logic last,
                               input logic [STAT_W-1:0] st);
        list_result_t r;
        r.value  = v;
        r.last   = last;
        r.status = st;
        r.count  = CNT_W'(list_len);
        due_results.push_back(r);
    endtask

    // Applies one request to the list copy and queues the results it causes
    task automatic update_list(input logic [MODE_W-1:0] mode,
                               input logic [DATA_W-1:0] operand);
        logic [STAT_W-1:0] st;
        int                n_hits;
        int                k;
        st = STAT_DONE;
        n_hits = 0;
        k = 0;
        if (mode == MODE_LIST_LE || mode == MODE_LIST_ALL)
        begin
            for (int i = 0; i < list_len; i++)
                if (is_listed(mode, list_vals[i], operand))
                    n_hits++;
            if (n_hits == 0)
                push_result('0, 1'b1, STAT_NONE);
            for (int i = 0; i < list_len; i++)
            begin
                if (is_listed(mode, list_vals[i], operand))
                begin
                    k++;
                    push_result(list_vals[i], k == n_hits, STAT_LISTED);
                end
            end
        end
        else
        begin
            case (mode)
                MODE_INS_FRONT, MODE_INS_BACK, MODE_APP_SIZE:
                    if (list_len >= DEPTH)
                        st = STAT_FULL;
                    else if (mode == MODE_INS_FRONT)
                        insert_value(0, operand);
                    else if (mode == MODE_INS_BACK)
                        insert_value(list_len, operand);
                    else
                        insert_value(list_len, DATA_W'(list_len));
                MODE_DEL_FRONT, MODE_DEL_BACK:
                    if (list_len == 0)
                        st = STAT_SHORT;
                    else
                        remove_value(mode == MODE_DEL_FRONT ? 0 : list_len - 1);
                MODE_DEL_LAST_N:
                    if ($signed(operand) < 0 || $signed(operand) >= list_len)
                        list_len = 0;
                    else
                        list_len = list_len - int'($signed(operand));
                MODE_DEL_SECOND:
                    if (list_len < 2)
                        st = STAT_SHORT;
                    else
                        remove_value(1);
                MODE_INS_BLAST:
                    if (list_len < 2)
                        st = STAT_SHORT;
                    else if (list_len >= DEPTH)
                        st = STAT_FULL;
                    else
                        insert_value(list_len - 1, operand);
                default:
                    ;
            endcase
            push_result('0, 1'b1, st);
        end
    endtask

    // ---------------- stimulus ----------------

    task automatic add_req(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] operand);
        list_request_t r;
        r.mode    = mode;
        r.operand = operand;
        r.pause   = 1'b0;
        queued_requests.push_back(r);
    endtask

    task automatic add_pause();
        list_request_t r;
        r.mode    = MODE_LIST_ALL;
        r.operand = '0;
        r.pause   = 1'b1;
        queued_requests.push_back(r);
    endtask

    function automatic logic [MODE_W-1:0] pick_mode(input int kind);
        int r;
        r = $urandom_range(99);
        case (kind)
            SEG_FILL:
                case ($urandom_range(3))
                    0:       return MODE_INS_FRONT;
                    1:       return MODE_INS_BACK;
                    2:       return MODE_APP_SIZE;
                    default: return MODE_INS_BLAST;
                endcase
            SEG_GROW:
                if (r < 20)      return MODE_INS_FRONT;
                else if (r < 40) return MODE_INS_BACK;
                else if (r < 55) return MODE_APP_SIZE;
                else if (r < 70) return MODE_INS_BLAST;
                else if (r < 77) return MODE_LIST_LE;
                else if (r < 82) return MODE_LIST_ALL;
            SEG_SHRINK:
                if (r < 20)      return MODE_DEL_FRONT;
                else if (r < 40) return MODE_DEL_BACK;
                else if (r < 55) return MODE_DEL_SECOND;
                else if (r < 65) return MODE_DEL_LAST_N;
                else if (r < 73) return MODE_LIST_LE;
                else if (r < 80) return MODE_LIST_ALL;
            default:
                if (r < 90)
                    return MODE_W'($urandom_range(MODE_LIST_ALL));
        endcase
        return MODE_W'($urandom_range(MODE_UNUSED_HI));
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand(input logic [MODE_W-1:0] mode);
        int r;
        r = $urandom_range(99);
        if (mode == MODE_DEL_LAST_N)
        begin
            // mostly short trims, some over-long and negative counts
            if (r < 60)      return DATA_W'($urandom_range(6));
            else if (r < 75) return DATA_W'($urandom_range(40, 7));
            else if (r < 90) return DATA_W'(-int'($urandom_range(4, 1)));
            else             return $urandom;
        end
        if (r < 10)      return VAL_MAX;
        else if (r < 20) return VAL_MIN;
        else if (r < 35) return DATA_W'(int'($urandom_range(20)) - 10);
        else             return $urandom;
    endfunction

    task automatic add_random(input int kind);
        logic [MODE_W-1:0] m;
        m = pick_mode(kind);
        add_req(m, pick_operand(m));
    endtask

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || req_taken))
        begin
            if (queued_requests.size() > 0 && queued_requests[0].pause)
            begin
                // sender waits until the block has drained everything
                if (due_results.size() == 0)
                    void'(queued_requests.pop_front());
                s_tvalid <= 1'b0;
            end
            else if (queued_requests.size() > 0 &&
                     (quiet || hold_left > 0 || $urandom_range(99) >= 20))
            begin
                next_req = queued_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.mode;
                s_tdata  <= next_req.operand;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output side: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && reqs_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(99) >= 20);
        end
    end

    // ---------------- monitor and predictor hookup ----------------

    always @(posedge clk)
    begin
        list_result_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: status %0d item_value %0d",
                           m_tuser, $signed(m_tdata[DATA_W-1:0]));
                    failed = 1'b1;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[DATA_W-1:0] !== want.value)
                    begin
                        $error("item_value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata[DATA_W-1:0]));
                        failed = 1'b1;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                        failed = 1'b1;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        failed = 1'b1;
                    end
                    if (m_tdata[DATA_W +: CNT_W] !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, m_tdata[DATA_W +: CNT_W]);
                        failed = 1'b1;
                    end
                end
            end
            // results checked first so a same-edge request cannot mask a stray result
            if (s_tvalid && s_tready)
            begin
                update_list(s_tuser, s_tdata);
                req_taken = 1'b1;
                reqs_taken++;
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bounded_list_engine_tb failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int n_rand;
        int len;
        int kind;
        bit paused;
        n_rand = 0;
        paused = 1'b0;

        // directed: empty list, short lists, extremes, every mode
        add_req(MODE_LIST_ALL, '0);
        add_req(MODE_LIST_LE, '0);
        add_req(MODE_DEL_FRONT, '0);
        add_req(MODE_DEL_BACK, '0);
        add_req(MODE_DEL_SECOND, '0);
        add_req(MODE_INS_BLAST, 32'd5);
        add_req(MODE_DEL_LAST_N, '0);
        add_req(MODE_INS_FRONT, VAL_MAX);
        add_req(MODE_INS_BLAST, 32'd1);
        add_req(MODE_DEL_SECOND, '0);
        add_req(MODE_INS_BACK, VAL_MIN);
        add_req(MODE_APP_SIZE, '0);
        add_req(MODE_INS_FRONT, '0);
        add_req(MODE_INS_BACK, 32'hffff_ffff);
        add_req(MODE_INS_BLAST, 32'h5555_aaaa);
        add_req(MODE_LIST_ALL, '0);
        add_req(MODE_LIST_LE, VAL_MIN);
        add_req(MODE_LIST_LE, VAL_MAX);
        add_req(MODE_LIST_LE, '0);
        add_req(MODE_DEL_SECOND, '0);
        add_req(MODE_DEL_LAST_N, 32'd1);
        add_req(MODE_UNUSED_LO, 32'hdead_beef);
        add_req(MODE_UNUSED_HI, VAL_MIN);
        add_req(MODE_DEL_LAST_N, VAL_MIN);
        add_req(MODE_INS_BACK, 32'd3);
        add_req(MODE_DEL_LAST_N, 32'd5);
        add_req(MODE_LIST_ALL, '0);
        add_pause();

        // fill to capacity, hit every full-store rejection, list the full store
        add_req(MODE_INS_BACK, $urandom);
        add_req(MODE_INS_BACK, $urandom);
        repeat (34)
            add_random(SEG_FILL);
        add_req(MODE_INS_FRONT, $urandom);
        add_req(MODE_INS_BACK, $urandom);
        add_req(MODE_APP_SIZE, '0);
        add_req(MODE_INS_BLAST, $urandom);
        add_req(MODE_LIST_ALL, '0);
        add_req(MODE_LIST_LE, $urandom);
        n_rand = 42;

        // random segments that push the size up and down
        while (n_rand < 225)
        begin
            kind = $urandom_range(SEG_MIX, SEG_GROW);
            len  = $urandom_range(30, 10);
            repeat (len)
                add_random(kind);
            n_rand += len;
            if (!paused && n_rand >= 120)
            begin
                add_pause();
                paused = 1'b1;
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (!failed && due_results.size() == 0)
            $display("bounded_list_engine_tb passed");
        else
            $display("bounded_list_engine_tb failed");
        $finish;
    end

endmodule
